// File: sv/sorted_axis_area_of_interest_core_defines.svh
// Assertion macros for the area-of-interest core checker.
// Used by saoi_checker.sv; no other dependencies.
`ifndef SORTED_AXIS_AREA_OF_INTEREST_CORE_DEFINES_SVH
`define SORTED_AXIS_AREA_OF_INTEREST_CORE_DEFINES_SVH

// Clocked property, disabled while reset is high
`define SAOI_ASSERT(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) p) \
    else $error("saoi assertion failed");

// Clocked property that also holds during reset
`define SAOI_ASSERT_ALWAYS(lbl, c, p) \
  lbl: assert property (@(posedge c) p) else $error("saoi assertion failed");

`endif

// File: sv/saoi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the area-of-interest core.
// No dependencies.
package saoi_pkg;

  localparam int MAX_ENTITIES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int ID_BITS          = 6;
  localparam int ID_SLOTS         = 64;
  localparam int FIELD_BITS       = 16;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_MOVE   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  localparam logic KIND_NEIGHBOR = 1'b0;
  localparam logic KIND_DONE     = 1'b1;

  // register index (byte address bit 2)
  localparam logic REG_X_RANGE = 1'b0;
  localparam logic REG_Y_RANGE = 1'b1;

endpackage

// File: sv/saoi_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready transaction).
// No dependencies.
interface saoi_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [5:0]         entity_id;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, req_type, entity_id, pos_x, pos_y, input ready);
  modport sink   (input valid, req_type, entity_id, pos_x, pos_y, output ready);
endinterface

interface saoi_res_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [1:0]         status;
  logic [5:0]         neighbor_id;
  logic signed [15:0] neighbor_x;
  logic signed [15:0] neighbor_y;
  logic               last;

  modport source (output valid, result_kind, status, neighbor_id, neighbor_x,
                  neighbor_y, last, input ready);
  modport sink   (input valid, result_kind, status, neighbor_id, neighbor_x,
                  neighbor_y, last, output ready);
endinterface

// File: sv/saoi_table.sv
`timescale 1ns / 1ps
// Entry table RAM: one write port, one registered read port with enable.
// No dependencies.
module saoi_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 38
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/sorted_axis_area_of_interest_core.sv
`timescale 1ns / 1ps
// Area-of-interest core: entities kept in one x-ordered table of {id, x, y}
// entries in a RAM with one write and one read port, walked by a small
// sequencer. Every request holds ready low until it finishes. Add runs a
// backward shift-and-insert pass, one entry a cycle. Remove and move first
// scan for the id, then close the gap; move then inserts again. A query
// scans for the id, then walks entries forward and backward, holding while
// the sink stalls a result. The rate is set by the one read port of the
// entry table.
module sorted_axis_area_of_interest_core import saoi_pkg::*; #(
  parameter int MAX_ENTITIES = MAX_ENTITIES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  saoi_req_if.sink    req,
  saoi_res_if.source  res
);

  localparam int IDX_W = $clog2(MAX_ENTITIES);
  localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
  localparam int EW    = ID_BITS + 2 * COORD_BITS;
  localparam int DW    = (COORD_BITS + 2 > FIELD_BITS + 2) ? COORD_BITS + 2 : FIELD_BITS + 2;
  localparam int XW    = COORD_BITS + FIELD_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_INS, S_QF_RD, S_QF_EV, S_QB_RD, S_QB_EV, S_DONE
  } state_t;

  state_t                  state;
  req_t                    req_q;
  status_t                 status_q;
  logic [ID_BITS-1:0]      id_q;
  logic [COORD_BITS-1:0]   nx, ny, cx, cy;
  logic [CNT_W-1:0]        count, ptr, pos, rd_tag;
  logic [ID_SLOTS-1:0]     present;
  logic [15:0]             x_range, y_range;
  logic                    rd_v;

  logic                    res_valid;
  logic                    res_kind;
  logic [1:0]              res_status;
  logic [ID_BITS-1:0]      res_id;
  logic [15:0]             res_x, res_y;
  logic                    res_last;

  // table ports
  logic                    re, we;
  logic [IDX_W-1:0]        ra, wa;
  logic [EW-1:0]           wd, rd_data, new_entry;

  logic [ID_BITS-1:0]      d_id;
  logic [COORD_BITS-1:0]   d_x, d_y;
  logic signed [DW-1:0]    dxf, dxb, dy, xr_w, yr_w;
  logic                    xf_out, xb_out, y_in, out_free, ins_shift, ins_end, found;
  logic                    res_load, stall;
  logic [XW-1:0]           px_ext, py_ext, dx_ext, dy_ext;

  saoi_table #(.DEPTH(MAX_ENTITIES), .WIDTH(EW)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(wa),
    .wdata(wd),
    .re   (re),
    .raddr(ra),
    .rdata(rd_data)
  );

  // config port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_X_RANGE: prdata = {16'd0, x_range};
      REG_Y_RANGE: prdata = {16'd0, y_range};
      default:     prdata = 32'd0;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // coordinate views
  assign px_ext    = XW'($unsigned(req.pos_x));
  assign py_ext    = XW'($unsigned(req.pos_y));
  assign new_entry = {id_q, nx, ny};
  assign d_id      = rd_data[EW-1 -: ID_BITS];
  assign d_x       = rd_data[2*COORD_BITS-1 -: COORD_BITS];
  assign d_y       = rd_data[COORD_BITS-1:0];
  assign dx_ext    = XW'($signed(d_x));
  assign dy_ext    = XW'($signed(d_y));

  // window compare
  assign dxf    = DW'($signed(d_x)) - DW'($signed(cx));
  assign dxb    = DW'($signed(cx)) - DW'($signed(d_x));
  assign dy     = DW'($signed(cy)) - DW'($signed(d_y));
  assign xr_w   = $signed(DW'(x_range));
  assign yr_w   = $signed(DW'(y_range));
  assign xf_out = dxf > xr_w;
  assign xb_out = dxb > xr_w;
  assign y_in   = (dy <= yr_w) && (dy >= -yr_w);

  assign out_free  = !res_valid || res.ready;
  assign ins_shift = rd_v && ($signed(d_x) > $signed(nx));
  assign ins_end   = (rd_v && !ins_shift) || (!rd_v && ptr == '0);
  assign found     = rd_v && (d_id == id_q);

  // table access and result load
  always_comb begin
    re       = 1'b0;
    ra       = ptr[IDX_W-1:0];
    we       = 1'b0;
    wa       = rd_tag[IDX_W-1:0];
    wd       = rd_data;
    res_load = 1'b0;
    stall    = 1'b0;
    case (state)
      S_SCAN: begin
        re = (ptr < count) && !found;
      end
      S_SHIFT: begin
        re = ptr < count;
        we = rd_v;
        wa = IDX_W'(rd_tag - 1'b1);
      end
      S_INS: begin
        re = (ptr != '0) && !ins_end;
        ra = IDX_W'(ptr - 1'b1);
        if (rd_v) begin
          we = 1'b1;
          wa = IDX_W'(rd_tag + 1'b1);
          wd = ins_shift ? rd_data : new_entry;
        end else if (ptr == '0) begin
          we = 1'b1;
          wa = '0;
          wd = new_entry;
        end
      end
      S_QF_RD: begin
        re = ptr < count;
      end
      S_QB_RD: begin
        re = ptr != '0;
        ra = IDX_W'(ptr - 1'b1);
      end
      S_QF_EV: begin
        if (!xf_out && y_in) begin
          stall    = !out_free;
          res_load = out_free;
        end
      end
      S_QB_EV: begin
        if (!xb_out && y_in) begin
          stall    = !out_free;
          res_load = out_free;
        end
      end
      S_DONE: begin
        res_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // sequencer, registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      present   <= '0;
      x_range   <= '0;
      y_range   <= '0;
      rd_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_v <= re;
      if (re) begin
        rd_tag <= CNT_W'(ra);
      end

      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_X_RANGE: x_range <= pwdata[15:0];
          REG_Y_RANGE: y_range <= pwdata[15:0];
          default: begin
          end
        endcase
      end

      if (res_load) begin
        res_valid <= 1'b1;
        if (state == S_DONE) begin
          res_kind   <= KIND_DONE;
          res_status <= status_q;
          res_id     <= '0;
          res_x      <= '0;
          res_y      <= '0;
          res_last   <= 1'b1;
        end else begin
          res_kind   <= KIND_NEIGHBOR;
          res_status <= ST_OK;
          res_id     <= d_id;
          res_x      <= dx_ext[15:0];
          res_y      <= dy_ext[15:0];
          res_last   <= 1'b0;
        end
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_q    <= req_t'(req.req_type);
            id_q     <= req.entity_id;
            nx       <= px_ext[COORD_BITS-1:0];
            ny       <= py_ext[COORD_BITS-1:0];
            status_q <= ST_OK;
            if (req_t'(req.req_type) == REQ_ADD) begin
              if (present[req.entity_id] || count >= CNT_W'(MAX_ENTITIES)) begin
                status_q <= ST_DUP;
                state    <= S_DONE;
              end else begin
                ptr   <= count;
                state <= S_INS;
              end
            end else if (!present[req.entity_id]) begin
              status_q <= ST_ABSENT;
              state    <= S_DONE;
            end else begin
              ptr   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (found) begin
            pos <= rd_tag;
            cx  <= d_x;
            cy  <= d_y;
            ptr <= rd_tag + 1'b1;
            case (req_q)
              REQ_REMOVE: begin
                present[id_q] <= 1'b0;
                state         <= S_SHIFT;
              end
              REQ_MOVE:  state <= S_SHIFT;
              REQ_QUERY: state <= S_QF_RD;
              default:   state <= S_DONE;
            endcase
          end else if (re) begin
            ptr <= ptr + 1'b1;
          end
        end
        S_SHIFT: begin
          if (re) begin
            ptr <= ptr + 1'b1;
          end else if (!rd_v) begin
            count <= count - 1'b1;
            if (req_q == REQ_MOVE) begin
              ptr   <= count - 1'b1;
              state <= S_INS;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_INS: begin
          if (re) begin
            ptr <= ptr - 1'b1;
          end
          if (ins_end) begin
            count         <= count + 1'b1;
            present[id_q] <= 1'b1;
            state         <= S_DONE;
          end
        end
        S_QF_RD: begin
          if (re) begin
            state <= S_QF_EV;
          end else begin
            ptr   <= pos;
            state <= S_QB_RD;
          end
        end
        S_QF_EV: begin
          if (xf_out) begin
            ptr   <= pos;
            state <= S_QB_RD;
          end else if (!stall) begin
            ptr   <= ptr + 1'b1;
            state <= S_QF_RD;
          end
        end
        S_QB_RD: begin
          state <= re ? S_QB_EV : S_DONE;
        end
        S_QB_EV: begin
          if (xb_out) begin
            state <= S_DONE;
          end else if (!stall) begin
            ptr   <= ptr - 1'b1;
            state <= S_QB_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.result_kind = res_kind;
  assign res.status      = res_status;
  assign res.neighbor_id = res_id;
  assign res.neighbor_x  = $signed(res_x);
  assign res.neighbor_y  = $signed(res_y);
  assign res.last        = res_last;

endmodule

// File: sv/saoi_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the area-of-interest core, bound to the top level.
// Depends on saoi_pkg and sorted_axis_area_of_interest_core_defines.svh.
`include "sorted_axis_area_of_interest_core_defines.svh"

module saoi_props import saoi_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_kind,
  input logic [1:0] res_status,
  input logic [5:0] res_id,
  input logic       res_last,
  input logic       pready
);

  // a stalled result holds
  `SAOI_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_id) && $stable(res_last))

  // one request at a time: busy right after acceptance
  `SAOI_ASSERT(a_busy_after_accept, clk, rst, req_valid && req_ready |=> !req_ready)

  // completion transactions are last and carry no neighbor
  `SAOI_ASSERT(a_done_form, clk, rst, res_valid && res_kind |-> res_last && res_id == 6'd0)

  // neighbor transactions are never last and always ok
  `SAOI_ASSERT(a_nbr_form, clk, rst, res_valid && !res_kind |-> !res_last && res_status == ST_OK)

  // config port never waits
  `SAOI_ASSERT_ALWAYS(a_pready, clk, pready)

endmodule

bind sorted_axis_area_of_interest_core saoi_props u_saoi_props (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.result_kind),
  .res_status(res.status),
  .res_id    (res.neighbor_id),
  .res_last  (res.last),
  .pready    (pready)
);

// File: tb/saoi_checker.sv
`timescale 1ns / 1ps
// Checker for the area-of-interest core: tracks the x-ordered entity table,
// predicts every result of each accepted request and compares. Uses saoi_pkg.
module saoi_checker import saoi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  saoi_req_if         req,
  saoi_res_if         res,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic [5:0]         nid;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               last;
  } aoi_result_t;

  aoi_result_t awaited_results[$];

  logic [15:0]        x_window, y_window;
  logic [5:0]         x_order [ID_SLOTS];
  int                 table_count;
  logic               present [ID_SLOTS];
  logic signed [15:0] ent_x [ID_SLOTS];
  logic signed [15:0] ent_y [ID_SLOTS];

  assign pending = awaited_results.size();

  function automatic int slot_of(logic [5:0] id);
    for (int i = 0; i < table_count; i++)
      if (x_order[i] == id) return i;
    return table_count;
  endfunction

  function automatic void unlink(logic [5:0] id);
    int p;
    p = slot_of(id);
    if (p >= table_count) return;
    for (int i = p; i + 1 < table_count; i++) x_order[i] = x_order[i + 1];
    table_count--;
  endfunction

  // insert after every entry with equal x
  function automatic void link_sorted(logic [5:0] id);
    int p;
    p = 0;
    if (table_count >= ID_SLOTS) return;
    while (p < table_count && ent_x[x_order[p]] <= ent_x[id]) p++;
    for (int i = table_count; i > p; i--) x_order[i] = x_order[i - 1];
    x_order[p] = id;
    table_count++;
  endfunction

  function automatic void push_neighbor(logic [5:0] o, ref int n);
    aoi_result_t r;
    r = '{KIND_NEIGHBOR, ST_OK, o, ent_x[o], ent_y[o], 1'b0};
    if (n < ID_SLOTS - 1) begin
      awaited_results.push_back(r);
      n++;
    end
  endfunction

  function automatic void predict_request(req_t op, logic [5:0] id,
                                          logic signed [15:0] px,
                                          logic signed [15:0] py);
    status_t st;
    int n, p;
    longint cx, cy, dy, xr, yr;
    aoi_result_t r;
    st = ST_OK;
    n = 0;
    if (op == REQ_ADD) begin
      if (present[id] || table_count >= MAX_ENTITIES_DEF) st = ST_DUP;
      else begin
        ent_x[id] = px;
        ent_y[id] = py;
        link_sorted(id);
        present[id] = 1'b1;
      end
    end else if (!present[id]) begin
      st = ST_ABSENT;
    end else if (op == REQ_REMOVE) begin
      unlink(id);
      present[id] = 1'b0;
    end else if (op == REQ_MOVE) begin
      unlink(id);
      ent_x[id] = px;
      ent_y[id] = py;
      link_sorted(id);
    end else begin
      p = slot_of(id);
      cx = ent_x[id];
      cy = ent_y[id];
      xr = x_window;
      yr = y_window;
      // forward walk in x order
      for (int i = p + 1; i < table_count; i++) begin
        dy = cy - ent_y[x_order[i]];
        if (ent_x[x_order[i]] - cx > xr) break;
        if (dy >= -yr && dy <= yr) push_neighbor(x_order[i], n);
      end
      // backward walk
      for (int i = p; i > 0; i--) begin
        dy = cy - ent_y[x_order[i - 1]];
        if (cx - ent_x[x_order[i - 1]] > xr) break;
        if (dy >= -yr && dy <= yr) push_neighbor(x_order[i - 1], n);
      end
    end
    r = '{KIND_DONE, st, 6'd0, 16'sd0, 16'sd0, 1'b1};
    awaited_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    aoi_result_t exp_r;
    if (rst) begin
      x_window <= '0;
      y_window <= '0;
      table_count = 0;
      awaited_results.delete();
      fail_count <= 0;
      for (int i = 0; i < ID_SLOTS; i++) present[i] = 1'b0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_X_RANGE) x_window <= pwdata[15:0];
        else y_window <= pwdata[15:0];
      end
      // result transaction is checked before the new request is predicted
      if (res.valid && res.ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = awaited_results.pop_front();
          if (res.result_kind !== exp_r.kind ||
              res.status !== exp_r.status ||
              res.neighbor_id !== exp_r.nid ||
              res.neighbor_x !== exp_r.nx ||
              res.neighbor_y !== exp_r.ny ||
              res.last !== exp_r.last) begin
            if (res.result_kind !== exp_r.kind)
              $error("result_kind exp %0d got %0d", exp_r.kind, res.result_kind);
            if (res.status !== exp_r.status)
              $error("status exp %0d got %0d", exp_r.status, res.status);
            if (res.neighbor_id !== exp_r.nid)
              $error("neighbor_id exp %0d got %0d", exp_r.nid, res.neighbor_id);
            if (res.neighbor_x !== exp_r.nx)
              $error("neighbor_x exp %0d got %0d", exp_r.nx, res.neighbor_x);
            if (res.neighbor_y !== exp_r.ny)
              $error("neighbor_y exp %0d got %0d", exp_r.ny, res.neighbor_y);
            if (res.last !== exp_r.last)
              $error("last exp %0d got %0d", exp_r.last, res.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req.valid && req.ready)
        predict_request(req_t'(req.req_type), req.entity_id, req.pos_x, req.pos_y);
    end
  end

endmodule

// File: tb/tb_sorted_axis_area_of_interest_core.sv
`timescale 1ns / 1ps
// Top of the area-of-interest core testbench: clock, reset, APB register
// writes and request stimulus. Uses saoi_pkg, saoi_if and saoi_checker.
module tb_sorted_axis_area_of_interest_core;
  import saoi_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          ids_used;

  saoi_req_if req_ch ();
  saoi_res_if res_ch ();

  sorted_axis_area_of_interest_core u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req_ch.sink), .res(res_ch.source)
  );

  saoi_checker u_checker (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .req(req_ch), .res(res_ch), .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.entity_id = '0;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
  end

  // result sink stall pattern: phases of full speed and of random stalls
  always @(posedge clk) begin
    int stall_mode;
    if (rst) res_ch.ready <= 1'b0;
    else begin
      stall_mode = ($urandom_range(0, 63) == 0) ? $urandom_range(0, 2) : stall_mode;
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_reg(logic reg_idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_request(req_t op, logic [5:0] id, logic [15:0] px,
                              logic [15:0] py);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.entity_id <= id;
    req_ch.pos_x <= px;
    req_ch.pos_y <= py;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic pause_req(int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  // random request biased toward a clustered set of ids and coordinates
  task automatic random_request(int id_span);
    req_t op;
    logic [15:0] px, py;
    op = req_t'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      px = 16'($urandom);
      py = 16'($urandom);
    end else begin
      px = 16'($urandom_range(0, 400) - 200);
      py = 16'($urandom_range(0, 400) - 200);
    end
    send_request(op, 6'($urandom_range(0, id_span)), px, py);
  endtask

  initial begin
    int burst;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, duplicates, absent ids, equal x ordering
    write_reg(REG_X_RANGE, 32'hFFFF_FFFF);
    write_reg(REG_Y_RANGE, 32'hFFFF_FFFF);
    send_request(REQ_QUERY, 6'd5, 16'h0, 16'h0);
    send_request(REQ_REMOVE, 6'd5, 16'h0, 16'h0);
    send_request(REQ_MOVE, 6'd5, 16'h0, 16'h0);
    send_request(REQ_ADD, 6'd0, 16'h8000, 16'h8000);
    send_request(REQ_ADD, 6'd63, 16'h7FFF, 16'h7FFF);
    send_request(REQ_ADD, 6'd63, 16'h0, 16'h0);
    send_request(REQ_ADD, 6'd10, 16'h0, 16'hFFFF);
    send_request(REQ_ADD, 6'd11, 16'h0, 16'h0001);
    send_request(REQ_ADD, 6'd12, 16'h0, 16'h0);
    send_request(REQ_QUERY, 6'd0, 16'h0, 16'h0);
    send_request(REQ_QUERY, 6'd63, 16'h0, 16'h0);
    send_request(REQ_QUERY, 6'd11, 16'h0, 16'h0);
    send_request(REQ_MOVE, 6'd10, 16'h0, 16'h5555);
    send_request(REQ_MOVE, 6'd0, 16'h7FFF, 16'hAAAA);
    send_request(REQ_QUERY, 6'd12, 16'h0, 16'h0);
    drain();
    write_reg(REG_X_RANGE, 32'h0);
    write_reg(REG_Y_RANGE, 32'h0);
    send_request(REQ_QUERY, 6'd12, 16'h0, 16'h0);
    send_request(REQ_QUERY, 6'd63, 16'h0, 16'h0);
    send_request(REQ_REMOVE, 6'd11, 16'h0, 16'h0);
    send_request(REQ_QUERY, 6'd12, 16'h0, 16'h0);
    drain();

    // random phases with several window settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(REG_X_RANGE, 32'd50);  write_reg(REG_Y_RANGE, 32'd80); end
        1: begin write_reg(REG_X_RANGE, 32'd300); write_reg(REG_Y_RANGE, 32'd0); end
        2: begin write_reg(REG_X_RANGE, $urandom); write_reg(REG_Y_RANGE, $urandom); end
        default: begin
          write_reg(REG_X_RANGE, 32'hFFFF); write_reg(REG_Y_RANGE, 32'hFFFF);
        end
      endcase
      ids_used = (phase == 3) ? 63 : 15;
      // phase 3 fills the table toward all 64 ids
      if (phase == 3)
        for (int i = 0; i < 64; i++)
          send_request(REQ_ADD, i[5:0], 16'($urandom), 16'($urandom));
      for (int k = 0; k < 15; ) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && k < 15; b++, k++) random_request(ids_used);
        if ($urandom_range(0, 2) == 0) pause_req($urandom_range(1, 12));
      end
      if (phase == 1) begin
        drain();
        random_request(ids_used);
      end
      drain();
    end

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
